// File: rtl/wfc_pkg.sv
`default_nettype none
package wfc_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int MAX_CHARS   = 32;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int USED_W = $clog2(MAX_ENTRIES + 1);
  localparam int POS_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LEN_W  = $clog2(MAX_CHARS + 1);
  localparam int CNT_W  = 16;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Result kinds
  localparam logic [1:0] KIND_COUNTED = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_NO_WORD = 2'd2;

  // One table row: the count, the length and the characters in cell order
  typedef struct packed {
    logic [CNT_W-1:0]               count;
    logic [LEN_W-1:0]               len;
    logic [MAX_CHARS-1:0][7:0]      chars;
  } row_t;

  // Word separators
  function automatic logic is_sep(input logic [7:0] c);
    logic r;
    case (c)
      8'h20, 8'h09, 8'h2C, 8'h2E, 8'h21, 8'h3F, 8'h3B, 8'h3A: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Upper-case letters are folded to lower case
  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/wfc_cell.sv
`default_nettype none
// One character cell of the pending-word chain.
module wfc_cell (
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire logic [7:0] d_in,
  output logic      [7:0] q
);

  logic [7:0] char_r;

  // Take the neighbour's character when the chain shifts
  always_ff @(posedge clk) begin
    if (shift) begin
      char_r <= d_in;
    end
  end

  assign q = char_r;

endmodule
`default_nettype wire

// File: rtl/wfc_table.sv
`default_nettype none
// Word table: one row per entry, one write and one registered read a cycle.
module wfc_table (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [wfc_pkg::IDX_W-1:0] wr_addr,
  input  wire wfc_pkg::row_t             wr_data,
  input  wire logic [wfc_pkg::IDX_W-1:0] rd_addr,
  output wfc_pkg::row_t                  rd_data
);

  wfc_pkg::row_t mem [wfc_pkg::MAX_ENTRIES];
  wfc_pkg::row_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// File: rtl/word_frequency_counter.sv
`default_nettype none
// Word frequency counter. Text enters one byte per transaction; in_tlast marks
// the final byte of a text. At the end of a word the table is searched one entry
// at a time, with a read state and a compare state per entry (one table read
// port), and the word's result is then handed over. At end of text a second
// pass over the stored words finds the most frequent word, whose characters then
// leave one at a time. The block takes one transaction at a time. The table keeps
// its contents until reset.
module word_frequency_counter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] text_byte
  input  wire logic        in_tlast,   // end_of_text
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [6:0] entry_index, [22:7] entry_count,
                                       // [23] is_new, [24] table_full,
                                       // [25] truncated, [33:26] char_out, zeros
  output logic      [1:0]  out_tuser,  // [1:0] kind
  output logic             out_tlast   // last
);

  localparam int NC = wfc_pkg::MAX_CHARS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_RD   = 8'b0000_0010,
    S_CMP  = 8'b0000_0100,
    S_OUT  = 8'b0000_1000,
    S_MRD  = 8'b0001_0000,
    S_MCMP = 8'b0010_0000,
    S_MLD  = 8'b0100_0000,
    S_CHR  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  logic [wfc_pkg::LEN_W-1:0]  len_r, len_nxt;
  logic                       trunc_r, trunc_nxt;
  logic                       eot_r, eot_nxt;
  logic [wfc_pkg::USED_W-1:0] used_r, used_nxt;
  logic [wfc_pkg::USED_W-1:0] i_r, i_nxt;
  logic [wfc_pkg::IDX_W-1:0]  best_r, best_nxt;
  logic [wfc_pkg::CNT_W-1:0]  best_cnt_r, best_cnt_nxt;
  logic [wfc_pkg::LEN_W-1:0]  ci_r, ci_nxt;
  wfc_pkg::row_t              hold_r, hold_nxt;

  logic                       o_valid_r, o_valid_nxt;
  logic [39:0]                o_data_r, o_data_nxt;
  logic [1:0]                 o_user_r, o_user_nxt;
  logic                       o_last_r, o_last_nxt;

  // Pending-word cell chain: cell 0 holds the newest character
  logic [NC-1:0][7:0] cell_q;
  logic               shift;
  logic [7:0]         low_byte;

  assign low_byte = wfc_pkg::to_lower(in_tdata);

  for (genvar k = 0; k < NC; k++) begin : g_cell
    wfc_cell u_cell (
      .clk  (clk),
      .shift(shift),
      .d_in ((k == 0) ? low_byte : cell_q[(k == 0) ? 0 : k-1]),
      .q    (cell_q[k])
    );
  end

  // Table
  logic                      wr_en;
  logic [wfc_pkg::IDX_W-1:0] wr_addr, rd_addr;
  wfc_pkg::row_t             wr_data, rd_data;

  wfc_table u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Masked comparison of the stored row against the pending cells
  logic match;
  always_comb begin
    match = (rd_data.len == len_r);
    for (int k = 0; k < NC; k++) begin
      if (k < int'(len_r) && rd_data.chars[k] != cell_q[k]) begin
        match = 1'b0;
      end
    end
  end

  // Result packing helper
  function automatic logic [39:0] pack(input logic [wfc_pkg::IDX_W-1:0] idx,
                                       input logic [15:0] cnt, input logic nw,
                                       input logic full, input logic tr,
                                       input logic [7:0] ch);
    logic [39:0] r;
    r = '0;
    r[6:0]   = 7'(idx);
    r[22:7]  = cnt;
    r[23]    = nw;
    r[24]    = full;
    r[25]    = tr;
    r[33:26] = ch;
    return r;
  endfunction

  logic                       in_acc;
  logic                       sep;
  logic [wfc_pkg::CNT_W-1:0]  cnt_inc;
  logic [wfc_pkg::POS_W-1:0]  chr_pos;
  logic [wfc_pkg::LEN_W-1:0]  chr_sel;

  assign in_acc  = in_tvalid && in_tready;
  assign sep     = wfc_pkg::is_sep(in_tdata);
  assign cnt_inc = (rd_data.count == wfc_pkg::CNT_MAX) ? rd_data.count
                                                       : rd_data.count + 1'b1;
  assign chr_sel = hold_r.len - ci_r - 1'b1;
  assign chr_pos = chr_sel[wfc_pkg::POS_W-1:0];

  // Control sequencer
  always_comb begin
    state_nxt    = state_r;
    ret_nxt      = ret_r;
    len_nxt      = len_r;
    trunc_nxt    = trunc_r;
    eot_nxt      = eot_r;
    used_nxt     = used_r;
    i_nxt        = i_r;
    best_nxt     = best_r;
    best_cnt_nxt = best_cnt_r;
    ci_nxt       = ci_r;
    hold_nxt     = hold_r;
    o_valid_nxt  = o_valid_r;
    o_data_nxt   = o_data_r;
    o_user_nxt   = o_user_r;
    o_last_nxt   = o_last_r;
    shift        = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = i_r[wfc_pkg::IDX_W-1:0];
    wr_data      = '0;
    wr_data.chars = cell_q;
    wr_data.len  = len_r;
    rd_addr      = i_r[wfc_pkg::IDX_W-1:0];
    in_tready    = (state_r == S_IDLE);

    if (o_valid_r && out_tready) begin
      o_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          eot_nxt = in_tlast;
          i_nxt   = '0;
          if (sep) begin
            if (len_r != '0) begin
              state_nxt = S_RD;
            end else if (in_tlast) begin
              // Nothing to flush: go straight to the search for the best word
              eot_nxt      = 1'b0;
              best_nxt     = '0;
              best_cnt_nxt = '0;
              state_nxt    = S_MRD;
            end
          end else begin
            if (len_r < wfc_pkg::LEN_W'(NC)) begin
              shift   = 1'b1;
              len_nxt = len_r + 1'b1;
            end else begin
              trunc_nxt = 1'b1;
            end
            if (in_tlast) begin
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        if (i_r == used_r) begin
          // No stored word matches: append it, or flag a full table
          if (used_r < wfc_pkg::USED_W'(wfc_pkg::MAX_ENTRIES)) begin
            wr_en        = 1'b1;
            wr_data.count = wfc_pkg::CNT_W'(1);
            o_data_nxt   = pack(used_r[wfc_pkg::IDX_W-1:0], 16'd1, 1'b1, 1'b0,
                                trunc_r, 8'd0);
            used_nxt     = used_r + 1'b1;
          end else begin
            o_data_nxt   = pack('0, 16'd0, 1'b0, 1'b1, trunc_r, 8'd0);
          end
          o_valid_nxt = 1'b1;
          o_user_nxt  = wfc_pkg::KIND_COUNTED;
          o_last_nxt  = 1'b0;
          len_nxt     = '0;
          trunc_nxt   = 1'b0;
          ret_nxt     = S_IDLE;
          state_nxt   = S_OUT;
        end else begin
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (match) begin
          wr_en         = 1'b1;
          wr_data.count = cnt_inc;
          o_valid_nxt   = 1'b1;
          o_data_nxt    = pack(i_r[wfc_pkg::IDX_W-1:0], cnt_inc, 1'b0, 1'b0,
                               trunc_r, 8'd0);
          o_user_nxt    = wfc_pkg::KIND_COUNTED;
          o_last_nxt    = 1'b0;
          len_nxt       = '0;
          trunc_nxt     = 1'b0;
          ret_nxt       = S_IDLE;
          state_nxt     = S_OUT;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        // Wait until the result register is free again
        if (!o_valid_r || out_tready) begin
          if (ret_r == S_IDLE && eot_r) begin
            eot_nxt      = 1'b0;
            i_nxt        = '0;
            best_nxt     = '0;
            best_cnt_nxt = '0;
            state_nxt    = S_MRD;
          end else begin
            state_nxt = ret_r;
          end
        end
      end
      S_MRD: begin
        if (i_r == used_r) begin
          if (best_cnt_r == '0) begin
            o_valid_nxt = 1'b1;
            o_data_nxt  = '0;
            o_user_nxt  = wfc_pkg::KIND_NO_WORD;
            o_last_nxt  = 1'b1;
            ret_nxt     = S_IDLE;
            state_nxt   = S_OUT;
          end else begin
            rd_addr   = best_r;
            state_nxt = S_MLD;
          end
        end else begin
          state_nxt = S_MCMP;
        end
      end
      S_MCMP: begin
        if (rd_data.count > best_cnt_r) begin
          best_cnt_nxt = rd_data.count;
          best_nxt     = i_r[wfc_pkg::IDX_W-1:0];
        end
        i_nxt     = i_r + 1'b1;
        state_nxt = S_MRD;
      end
      S_MLD: begin
        hold_nxt  = rd_data;
        ci_nxt    = '0;
        state_nxt = S_CHR;
      end
      S_CHR: begin
        o_valid_nxt = 1'b1;
        o_data_nxt  = pack(best_r, best_cnt_r, 1'b0, 1'b0, 1'b0,
                           hold_r.chars[chr_pos]);
        o_user_nxt  = wfc_pkg::KIND_CHAR;
        o_last_nxt  = (ci_r + 1'b1 == hold_r.len);
        ci_nxt      = ci_r + 1'b1;
        ret_nxt     = (ci_r + 1'b1 == hold_r.len) ? S_IDLE : S_CHR;
        state_nxt   = S_OUT;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ret_r     <= S_IDLE;
      len_r     <= '0;
      trunc_r   <= 1'b0;
      eot_r     <= 1'b0;
      used_r    <= '0;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ret_r     <= ret_nxt;
      len_r     <= len_nxt;
      trunc_r   <= trunc_nxt;
      eot_r     <= eot_nxt;
      used_r    <= used_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    best_r     <= best_nxt;
    best_cnt_r <= best_cnt_nxt;
    ci_r       <= ci_nxt;
    hold_r     <= hold_nxt;
    o_data_r   <= o_data_nxt;
    o_user_r   <= o_user_nxt;
    o_last_r   <= o_last_nxt;
  end

  assign out_tvalid = o_valid_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_user_r;
  assign out_tlast  = o_last_r;

endmodule
`default_nettype wire

// File: tb/sv/word_frequency_counter_checker.sv
`timescale 1ns / 100ps
module word_frequency_counter_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,
  input  wire logic        in_tlast,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,
  input  wire logic [1:0]  out_tuser,
  input  wire logic        out_tlast,
  output int               errors,
  output int               waiting,
  output int               results_seen,
  output int               words_stored
);

  // One expected result, field by field
  typedef struct packed {
    logic [1:0]  kind;
    logic [6:0]  idx;
    logic [15:0] cnt;
    logic        is_new;
    logic        full;
    logic        cut;
    logic [7:0]  ch;
    logic        last;
  } tally_t;

  tally_t      due_q[$];

  // Predicted state: the word being built and the table of distinct words
  logic [7:0]  word_buf[wfc_pkg::MAX_CHARS];
  int          word_len;
  bit          word_cut;
  logic [7:0]  dict_chars[wfc_pkg::MAX_ENTRIES][wfc_pkg::MAX_CHARS];
  int          dict_len[wfc_pkg::MAX_ENTRIES];
  int          dict_cnt[wfc_pkg::MAX_ENTRIES];
  int          dict_used;

  initial begin
    errors       = 0;
    waiting      = 0;
    results_seen = 0;
    words_stored = 0;
    word_len     = 0;
    word_cut     = 0;
    dict_used    = 0;
  end

  function automatic bit splits_words(logic [7:0] c);
    case (c)
      8'h20, 8'h09, 8'h2C, 8'h2E, 8'h21, 8'h3F, 8'h3B, 8'h3A: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // Look the finished word up, count it and queue its result.
  task automatic close_word();
    int     hit;
    int     i;
    int     j;
    bit     same;
    tally_t t;
    hit = -1;
    for (i = 0; i < dict_used && hit < 0; i++) begin
      if (dict_len[i] == word_len) begin
        same = 1'b1;
        for (j = 0; j < word_len; j++) begin
          if (dict_chars[i][j] !== word_buf[j]) same = 1'b0;
        end
        if (same) hit = i;
      end
    end
    t      = '0;
    t.kind = wfc_pkg::KIND_COUNTED;
    t.cut  = word_cut;
    if (hit >= 0) begin
      if (dict_cnt[hit] < int'(wfc_pkg::CNT_MAX)) dict_cnt[hit]++;
      t.idx = 7'(hit);
      t.cnt = 16'(dict_cnt[hit]);
    end else if (dict_used < wfc_pkg::MAX_ENTRIES) begin
      for (j = 0; j < word_len; j++) dict_chars[dict_used][j] = word_buf[j];
      dict_len[dict_used] = word_len;
      dict_cnt[dict_used] = 1;
      t.idx    = 7'(dict_used);
      t.cnt    = 16'd1;
      t.is_new = 1'b1;
      dict_used++;
    end else begin
      t.full = 1'b1;
    end
    due_q.push_back(t);
    word_len = 0;
    word_cut = 0;
  endtask

  // Predict everything that one accepted byte causes.
  task automatic take_byte(logic [7:0] b, logic eot);
    logic [7:0] c;
    int         best;
    int         best_cnt;
    int         i;
    tally_t     t;
    c = b;
    if (splits_words(c)) begin
      if (word_len > 0) close_word();
    end else begin
      if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
      if (word_len < wfc_pkg::MAX_CHARS) begin
        word_buf[word_len] = c;
        word_len++;
      end else begin
        word_cut = 1'b1;
      end
    end
    if (eot) begin
      if (word_len > 0) close_word();
      best     = 0;
      best_cnt = 0;
      for (i = 0; i < dict_used; i++) begin
        if (dict_cnt[i] > best_cnt) begin
          best_cnt = dict_cnt[i];
          best     = i;
        end
      end
      if (best_cnt == 0) begin
        t      = '0;
        t.kind = wfc_pkg::KIND_NO_WORD;
        t.last = 1'b1;
        due_q.push_back(t);
      end else begin
        for (i = 0; i < dict_len[best]; i++) begin
          t      = '0;
          t.kind = wfc_pkg::KIND_CHAR;
          t.idx  = 7'(best);
          t.cnt  = 16'(best_cnt);
          t.ch   = dict_chars[best][i];
          t.last = (i + 1 == dict_len[best]);
          due_q.push_back(t);
        end
      end
    end
  endtask

  task automatic report(string what, int want, int got);
    $display("%0t ns: %s: expected %0h, got %0h", $time, what, want, got);
    errors++;
  endtask

  // Predict on input transactions, compare on output transactions.
  always @(posedge clk) begin
    tally_t t;
    if (rst_n) begin
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (due_q.size() == 0) begin
          report("result with nothing expected", 0, int'(out_tdata[31:0]));
        end else begin
          t = due_q.pop_front();
          if (out_tuser !== t.kind)
            report("kind", int'(t.kind), int'(out_tuser));
          if (out_tdata[6:0] !== t.idx)
            report("entry_index", int'(t.idx), int'(out_tdata[6:0]));
          if (out_tdata[22:7] !== t.cnt)
            report("entry_count", int'(t.cnt), int'(out_tdata[22:7]));
          if (out_tdata[23] !== t.is_new)
            report("is_new", int'(t.is_new), int'(out_tdata[23]));
          if (out_tdata[24] !== t.full)
            report("table_full", int'(t.full), int'(out_tdata[24]));
          if (out_tdata[25] !== t.cut)
            report("truncated", int'(t.cut), int'(out_tdata[25]));
          if (out_tdata[33:26] !== t.ch)
            report("char_out", int'(t.ch), int'(out_tdata[33:26]));
          if (out_tdata[39:34] !== 6'd0)
            report("padding", 0, int'(out_tdata[39:34]));
          if (out_tlast !== t.last)
            report("last", int'(t.last), int'(out_tlast));
        end
      end
      waiting      = due_q.size();
      words_stored = dict_used;
    end
  end

endmodule

// File: tb/sv/word_frequency_counter_tb.sv
`timescale 1ns / 100ps
module word_frequency_counter_tb;

  localparam int QUIET_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int errors;
  int waiting;
  int results_seen;
  int words_stored;
  int bytes_sent = 0;
  int quiet = 0;
  int hold_left = 0;
  bit held_once = 0;
  bit calm = 0;

  logic [7:0] seps[8] = '{8'h20, 8'h09, 8'h2C, 8'h2E, 8'h21, 8'h3F, 8'h3B, 8'h3A};

  word_frequency_counter u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  word_frequency_counter_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .errors(errors), .waiting(waiting), .results_seen(results_seen),
    .words_stored(words_stored)
  );

  always #4 clk = ~clk;

  // Receiver: random stalls, one long hold-off, none in calm stretches.
  always @(negedge clk) begin
    if (!held_once && results_seen >= 20) begin
      held_once = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (calm) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 17);
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet);
      $display("word_frequency_counter: mismatch");
      $finish;
    end
  end

  // Offer one byte and wait for its transaction.
  task automatic send(logic [7:0] b, logic eot);
    @(negedge clk);
    if (!calm && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
    in_tdata  <= b;
    in_tlast  <= eot;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(4))
        0: c = 8'h61;
        1: c = 8'h62;
        2: c = 8'h41;
        3: c = 8'h42;
        default: c = 8'h63;
      endcase
    end else begin
      do c = 8'($urandom_range(255)); while (c inside {8'h20, 8'h09, 8'h2C, 8'h2E,
                                                       8'h21, 8'h3F, 8'h3B, 8'h3A});
    end
    return c;
  endfunction

  // Words of random content and length, mostly short, a few over the limit.
  task automatic random_text(int n);
    int stop;
    int len;
    int i;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      len = ($urandom_range(99) < 5) ? $urandom_range(40, 33) : $urandom_range(3, 1);
      if ($urandom_range(99) < 8) len = 0;
      for (i = 0; i < len; i++) send(pick_char(), $urandom_range(39) == 0);
      repeat ($urandom_range(2, 1)) send(seps[$urandom_range(7)], $urandom_range(29) == 0);
    end
  endtask

  initial begin
    int         i;
    int         extra;
    logic [7:0] b;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, case folding, zero and top bytes, every separator.
    send(8'h20, 1'b1);
    send(8'h41, 1'b0);
    send(8'h20, 1'b0);
    send(8'h20, 1'b0);
    send(8'h61, 1'b0);
    send(8'h09, 1'b0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b0);
    send(8'h5A, 1'b0);
    send(8'h2C, 1'b0);
    send(8'h42, 1'b0);
    send(8'h3F, 1'b0);
    send(8'h3B, 1'b0);
    send(8'h62, 1'b0);
    send(8'h21, 1'b0);
    send(8'h7A, 1'b0);
    send(8'h2E, 1'b0);
    send(8'h62, 1'b0);
    send(8'h3A, 1'b1);
    send(8'h61, 1'b1);

    // Random text, with a pause until the result queue drains.
    random_text(60);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (waiting == 0);
    calm = 1'b1;
    random_text(30);
    calm = 1'b0;
    random_text(30);

    // Fill the table with one-byte words until a few new ones are dropped.
    i     = 0;
    extra = 0;
    while (extra < 4 && i < 256) begin
      b = 8'(i + 128);
      i++;
      if (!(b inside {8'h20, 8'h09, 8'h2C, 8'h2E, 8'h21, 8'h3F, 8'h3B, 8'h3A})) begin
        if (words_stored >= wfc_pkg::MAX_ENTRIES) extra++;
        send(b, 1'b0);
        send(seps[$urandom_range(7)], 1'b0);
      end
    end
    random_text(20);
    send(8'h61, 1'b1);

    @(negedge clk);
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;
    wait (waiting == 0);
    repeat (600) @(posedge clk);

    $display("sent %0d bytes, checked %0d results, table ended with %0d words",
             bytes_sent, results_seen, words_stored);
    $display("covered empty table, case folding, truncation and a full table");
    if (errors == 0 && waiting == 0) begin
      $display("word_frequency_counter: match");
    end else begin
      $display("word_frequency_counter: mismatch");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/wfc_pkg.sv
rtl/wfc_cell.sv
rtl/wfc_table.sv
rtl/word_frequency_counter.sv
tb/sv/word_frequency_counter_checker.sv
tb/sv/word_frequency_counter_tb.sv
